// ----- src/ptc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants
// Payload structs, sequencer states, register indexes and datapath widths
// for the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // operation codes
   localparam logic OP_TEMP = 1'b0;
   localparam logic OP_PRES = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TRIM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_TRIM_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_TRIM_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_TRIM_C = 2'd3;
   localparam int CSR_DATA_W = 64;

   // shared multiplier: A x B, B taken one byte a step, top byte signed
   localparam int MUL_A_W     = 64;
   localparam int MUL_B_W     = 32;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_DIGIT_W = 8;
   localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

   // divider: numerator is |num| * 3125, quotient saturates at 2^36
   localparam int DIV_NUM_W = 78;
   localparam int DIV_DEN_W = 40;
   localparam int DIV_QUO_W = 37;
   localparam int DIV_CNT_W = $clog2(DIV_QUO_W);
   localparam logic [DIV_QUO_W-1:0] DIV_QLIMIT = {1'b1, {(DIV_QUO_W-1){1'b0}}};

   localparam int FINE_OFFSET = 128000;
   localparam int PRES_SCALE  = 3125;
   localparam int ADC_FULL    = 1048576;
   localparam int ROUND_HALF  = 128;

   typedef struct packed {
      logic        operation;
      logic [19:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               divide_by_zero;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_MUL1,
      ST_T_MUL2,
      ST_T_MUL3,
      ST_T_OUT,
      ST_P_SQ,
      ST_P_V2A,
      ST_P_V2B,
      ST_P_V1A,
      ST_P_V1B,
      ST_P_DEN,
      ST_P_CHK,
      ST_P_SCALE,
      ST_P_DIV,
      ST_P_SS,
      ST_P_C9,
      ST_P_C8,
      ST_P_OUT,
      ST_DONE
   } state_type;

endpackage

// ----- src/ptc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_mul: shared multi-cycle signed multiplier
// Horner form over the bytes of B, most significant (signed) byte first.
// ----------------------------------------------------------------------------
module ptc_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ptc_pkg::MUL_A_W-1:0]  a,
   input  logic signed [ptc_pkg::MUL_B_W-1:0]  b,
   output logic                                done,
   output logic signed [ptc_pkg::MUL_P_W-1:0]  prod
);
   import ptc_pkg::*;

   logic signed [MUL_A_W-1:0]   a_ff, a_in;
   logic [MUL_B_W-1:0]          b_ff, b_in;
   logic signed [MUL_P_W-1:0]   acc_ff, acc_in;
   logic [MUL_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic signed [MUL_DIGIT_W:0] digit;
   logic signed [MUL_A_W+MUL_DIGIT_W:0] pp;

   // top byte carries the sign, lower bytes are unsigned
   assign digit = $signed({(cnt_ff == '0) ? b_ff[MUL_B_W-1] : 1'b0,
                           b_ff[MUL_B_W-1 -: MUL_DIGIT_W]});
   assign pp = a_ff * digit;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         acc_in = (acc_ff <<< MUL_DIGIT_W) + MUL_P_W'(pp);
         b_in   = b_ff << MUL_DIGIT_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- src/ptc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div: restoring divider, one quotient bit per cycle
// Quotient saturates at 2^36; an early compare catches quotients >= 2^37.
// ----------------------------------------------------------------------------
module ptc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ptc_pkg::DIV_NUM_W-1:0]   num,
   input  logic [ptc_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [ptc_pkg::DIV_QUO_W-1:0]   quo
);
   import ptc_pkg::*;

   localparam int HI_W = DIV_NUM_W - DIV_QUO_W;

   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sat_ff, sat_in;
   logic [DIV_DEN_W:0]   trial;
   logic [HI_W-1:0]      hi;

   assign trial = {rem_ff, quo_ff[DIV_QUO_W-1]};
   assign hi    = num[DIV_NUM_W-1:DIV_QUO_W];

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         den_in = den;
         cnt_in = '0;
         if (HI_W'(hi) >= HI_W'(den)) begin
            sat_in  = 1'b1;
            done_in = 1'b1;
         end else begin
            sat_in  = 1'b0;
            rem_in  = hi[DIV_DEN_W-1:0];
            quo_in  = num[DIV_QUO_W-1:0];
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quo  = (sat_ff || quo_ff > DIV_QLIMIT) ? DIV_QLIMIT : quo_ff;

endmodule

// ----- src/pressure_temp_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation: barometric sensor compensation
// Turns raw 20-bit readings into temperature (0.01 C) and pressure (Pa Q24.8)
// with trimming coefficients held in four configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/stall): operation (0 temperature, 1 pressure) and
//    raw_sample. A transfer happens when req_valid is high and req_stall low.
//  - rsp channel (valid/stall): one result per request, held in an output
//    register until the receiver takes it with rsp_stall low.
//  - csr port: csr_we with csr_index/csr_wdata writes one trim register;
//    write only while the block is idle.
//  - A temperature item updates the kept fine temperature; pressure items
//    use the last value (zero after reset).
// Datapath: every product runs through one byte-serial multiplier and the
//  quotient through one bit-serial divider, which stops early when the
//  quotient saturates; a zero divisor skips the divider. One item at a
//  time: req_stall stays high from the transfer until the result is loaded
//  into the output register.
// Reset: synchronous; clears trim registers, fine temperature, sequencer and
//  output valid.
// Stall: a result waits in the sequencer's last step while the output
//  register still holds an untaken result.
// ----------------------------------------------------------------------------
module pressure_temp_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ptc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ptc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ptc_pkg::*;

   // trim registers
   logic [47:0] temp_trim_ff, temp_trim_in;
   logic [63:0] pres_a_ff, pres_a_in;
   logic [63:0] pres_b_ff, pres_b_in;
   logic [15:0] pres_c_ff, pres_c_in;

   // sequencer and datapath state
   state_type          state_ff, state_in;
   logic               launched_ff, launched_in;
   logic [19:0]        sample_ff, sample_in;
   logic signed [31:0] fine_ff, fine_in;
   logic signed [63:0] acc1_ff, acc1_in;
   logic signed [63:0] acc2_ff, acc2_in;
   logic signed [49:0] sq_ff, sq_in;
   logic signed [DIV_DEN_W-1:0] den_ff, den_in;
   logic [63:0]        nm_ff, nm_in;
   logic               neg_ff, neg_in;
   logic signed [37:0] p_ff, p_in;
   rsp_type            rslt_ff, rslt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // coefficients
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   // shared units
   logic                       mul_start, mul_done;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_prod;
   logic                       div_start, div_done;
   logic [DIV_DEN_W-1:0]       div_den;
   logic [DIV_QUO_W-1:0]       div_quo;

   // derived terms
   logic signed [18:0] ta;
   logic signed [16:0] tb;
   logic signed [32:0] dv;
   logic signed [24:0] ps;
   logic signed [34:0] t5;
   logic signed [26:0] tc;
   logic signed [63:0] num;
   logic signed [63:0] psum;
   logic signed [63:0] pres;
   logic               mul_state;

   assign t1 = temp_trim_ff[15:0];
   assign t2 = $signed(temp_trim_ff[31:16]);
   assign t3 = $signed(temp_trim_ff[47:32]);
   assign p1 = pres_a_ff[15:0];
   assign p2 = $signed(pres_a_ff[31:16]);
   assign p3 = $signed(pres_a_ff[47:32]);
   assign p4 = $signed(pres_a_ff[63:48]);
   assign p5 = $signed(pres_b_ff[15:0]);
   assign p6 = $signed(pres_b_ff[31:16]);
   assign p7 = $signed(pres_b_ff[47:32]);
   assign p8 = $signed(pres_b_ff[63:48]);
   assign p9 = $signed(pres_c_ff);

   assign ta = $signed({2'b00, sample_ff[19:3]}) - $signed({2'b00, t1, 1'b0});
   assign tb = $signed({1'b0, sample_ff[19:4]}) - $signed({1'b0, t1});
   assign dv = 33'(fine_ff) - 33'sd128000;
   assign ps = p_ff[37:13];

   // temperature = (fine * 5 + 128) >> 8
   assign t5 = (35'(fine_ff) <<< 2) + 35'(fine_ff) + 35'(ROUND_HALF);
   assign tc = t5[34:8];

   // numerator = (2^20 - adc) * 2^31 - v2
   assign num = $signed({12'b0, 21'(ADC_FULL) - {1'b0, sample_ff}, 31'b0}) - acc2_ff;

   assign psum = 64'(p_ff) + acc1_ff + acc2_ff;
   assign pres = 64'($signed(psum[63:8])) + $signed({{44{p7[15]}}, p7, 4'b0});

   assign div_den = den_ff[DIV_DEN_W-1] ? DIV_DEN_W'(-den_ff) : DIV_DEN_W'(den_ff);

   ptc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ptc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_prod[DIV_NUM_W-1:0]),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // multiplier operand select
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_state = 1'b1;
      case (state_ff)
         ST_T_MUL1:  begin mul_a = 64'(ta);       mul_b = 32'(t2);  end
         ST_T_MUL2:  begin mul_a = 64'(tb);       mul_b = 32'(tb);  end
         ST_T_MUL3:  begin mul_a = acc2_ff;       mul_b = 32'(t3);  end
         ST_P_SQ:    begin mul_a = 64'(dv);       mul_b = 32'(dv);  end
         ST_P_V2A:   begin mul_a = 64'(sq_ff);    mul_b = 32'(p6);  end
         ST_P_V2B:   begin mul_a = 64'(dv);       mul_b = 32'(p5);  end
         ST_P_V1A:   begin mul_a = 64'(sq_ff);    mul_b = 32'(p3);  end
         ST_P_V1B:   begin mul_a = 64'(dv);       mul_b = 32'(p2);  end
         ST_P_DEN:   begin mul_a = acc1_ff;       mul_b = $signed({16'b0, p1}); end
         ST_P_SCALE: begin mul_a = $signed(nm_ff); mul_b = 32'(PRES_SCALE); end
         ST_P_SS:    begin mul_a = 64'(ps);       mul_b = 32'(ps);  end
         ST_P_C9:    begin mul_a = 64'(sq_ff);    mul_b = 32'(p9);  end
         ST_P_C8:    begin mul_a = 64'(p_ff);     mul_b = 32'(p8);  end
         default:    mul_state = 1'b0;
      endcase
   end

   assign mul_start = mul_state && !launched_ff;
   assign div_start = (state_ff == ST_P_DIV) && !launched_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.operation == OP_PRES) ? ST_P_SQ : ST_T_MUL1;
            end
         end
         ST_T_MUL1:  if (mul_done) state_in = ST_T_MUL2;
         ST_T_MUL2:  if (mul_done) state_in = ST_T_MUL3;
         ST_T_MUL3:  if (mul_done) state_in = ST_T_OUT;
         ST_T_OUT:   state_in = ST_DONE;
         ST_P_SQ:    if (mul_done) state_in = ST_P_V2A;
         ST_P_V2A:   if (mul_done) state_in = ST_P_V2B;
         ST_P_V2B:   if (mul_done) state_in = ST_P_V1A;
         ST_P_V1A:   if (mul_done) state_in = ST_P_V1B;
         ST_P_V1B:   if (mul_done) state_in = ST_P_DEN;
         ST_P_DEN:   if (mul_done) state_in = ST_P_CHK;
         ST_P_CHK:   state_in = (den_ff == '0) ? ST_DONE : ST_P_SCALE;
         ST_P_SCALE: if (mul_done) state_in = ST_P_DIV;
         ST_P_DIV:   if (div_done) state_in = ST_P_SS;
         ST_P_SS:    if (mul_done) state_in = ST_P_C9;
         ST_P_C9:    if (mul_done) state_in = ST_P_C8;
         ST_P_C8:    if (mul_done) state_in = ST_P_OUT;
         ST_P_OUT:   state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      temp_trim_in = temp_trim_ff;
      pres_a_in    = pres_a_ff;
      pres_b_in    = pres_b_ff;
      pres_c_in    = pres_c_ff;
      sample_in    = sample_ff;
      fine_in      = fine_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      nm_in        = nm_ff;
      neg_in       = neg_ff;
      p_in         = p_ff;
      rslt_in      = rslt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         case (csr_index)
            CSR_TEMP_TRIM:   temp_trim_in = csr_wdata[47:0];
            CSR_PRES_TRIM_A: pres_a_in    = csr_wdata;
            CSR_PRES_TRIM_B: pres_b_in    = csr_wdata;
            CSR_PRES_TRIM_C: pres_c_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      // a launch is outstanding from start until the unit reports done
      if (mul_done || div_done) begin
         launched_in = 1'b0;
      end else if (mul_start || div_start) begin
         launched_in = 1'b1;
      end else begin
         launched_in = launched_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_data.raw_sample;
            end
         end
         ST_T_MUL1:  if (mul_done) acc1_in = mul_prod[74:11];
         ST_T_MUL2:  if (mul_done) acc2_in = mul_prod[75:12];
         ST_T_MUL3: begin
            if (mul_done) begin
               fine_in = 32'(acc1_ff + mul_prod[77:14]);
            end
         end
         ST_T_OUT: begin
            rslt_in.pressure_q24_8 = '0;
            rslt_in.divide_by_zero = 1'b0;
            if (tc > 27'sd8388607) begin
               rslt_in.temperature_centi = 24'sh7FFFFF;
            end else if (tc < -27'sd8388608) begin
               rslt_in.temperature_centi = 24'sh800000;
            end else begin
               rslt_in.temperature_centi = tc[23:0];
            end
         end
         ST_P_SQ:  if (mul_done) sq_in = mul_prod[49:0];
         ST_P_V2A: if (mul_done) acc2_in = mul_prod[63:0];
         ST_P_V2B: begin
            if (mul_done) begin
               acc2_in = acc2_ff + $signed({mul_prod[46:0], 17'b0})
                       + $signed({{13{p4[15]}}, p4, 35'b0});
            end
         end
         ST_P_V1A: if (mul_done) acc1_in = mul_prod[71:8];
         ST_P_V1B: begin
            // x = 2^47 + v1
            if (mul_done) begin
               acc1_in = acc1_ff + $signed({mul_prod[51:0], 12'b0})
                       + $signed({16'b0, 1'b1, 47'b0});
            end
         end
         ST_P_DEN: if (mul_done) den_in = mul_prod[72:33];
         ST_P_CHK: begin
            neg_in = num[63] ^ den_ff[DIV_DEN_W-1];
            nm_in  = num[63] ? 64'(-num) : 64'(num);
            if (den_ff == '0) begin
               rslt_in.temperature_centi = '0;
               rslt_in.pressure_q24_8    = '0;
               rslt_in.divide_by_zero    = 1'b1;
            end
         end
         ST_P_DIV: begin
            if (div_done) begin
               p_in = neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
            end
         end
         ST_P_SS: if (mul_done) sq_in = mul_prod[49:0];
         ST_P_C9: if (mul_done) acc1_in = mul_prod[88:25];
         ST_P_C8: if (mul_done) acc2_in = mul_prod[82:19];
         ST_P_OUT: begin
            rslt_in.temperature_centi = '0;
            rslt_in.divide_by_zero    = 1'b0;
            if (pres[63]) begin
               rslt_in.pressure_q24_8 = '0;
            end else if (pres[63:32] != '0) begin
               rslt_in.pressure_q24_8 = '1;
            end else begin
               rslt_in.pressure_q24_8 = pres[31:0];
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rslt_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= '0;
         temp_trim_ff <= '0;
         pres_a_ff    <= '0;
         pres_b_ff    <= '0;
         pres_c_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_ff      <= fine_in;
         temp_trim_ff <= temp_trim_in;
         pres_a_ff    <= pres_a_in;
         pres_b_ff    <= pres_b_in;
         pres_c_ff    <= pres_c_in;
      end
      sample_ff   <= sample_in;
      acc1_ff     <= acc1_in;
      acc2_ff     <= acc2_in;
      sq_ff       <= sq_in;
      den_ff      <= den_in;
      nm_ff       <= nm_in;
      neg_ff      <= neg_in;
      p_ff        <= p_in;
      rslt_ff     <= rslt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mul_done_launched: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> launched_ff)
      else $error("multiplier done without a launch");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_P_DIV)
      else $error("divider done outside divide step");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> den_ff != '0)
      else $error("divider started with zero divisor");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !launched_ff)
      else $error("unit launch pending while idle");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pressure/temperature compensation block
// A directed table first: reset trims, the standard trim set, extreme trims,
// a zero divisor and a saturated quotient. Random trim phases follow. A model
// of the compensation math inside this file predicts each result that a table
// row does not give itself, and a scoreboard compares each rsp transfer field
// by field with the oldest prediction. Both channels idle and stall at random,
// and one long rsp hold-off fills the block up and stalls req.
// ----------------------------------------------------------------------------
module testbench;
   import ptc_pkg::*;

   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 150;
   localparam int QUIET_ITEMS   = 150;    // tail of the run without idling
   localparam int HOLD_CYCLES   = 500;    // long rsp hold-off
   localparam int HOLD_AFTER    = 400;    // transfers seen before the hold-off
   localparam int DRAIN_CYCLES  = 40;
   localparam longint QLIM      = 64'sd1 << 36;

   // standard trim set, packed as the registers hold it
   localparam logic [63:0] STD_TEMP_TRIM = {16'h0, 16'hFC18, 16'h6743, 16'h6B70};
   localparam logic [63:0] STD_PRES_A    = {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D};
   localparam logic [63:0] STD_PRES_B    = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
   localparam logic [63:0] STD_PRES_C    = 64'd6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TEMP_TRIM;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pressure_temp_compensation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // --- compensation model: own copy of trims and kept fine temperature ---
   logic [63:0] temp_trim_m, pres_a_m, pres_b_m, pres_c_m;
   int fine_temp_m;

   rsp_type expected_rsps[$];
   int errors = 0;
   int accepted = 0;
   int results_seen = 0;
   int temp_count = 0, pres_count = 0, dz_count = 0, sat_count = 0;
   bit quiet = 1'b0;
   bit run_done = 1'b0;

   // typed expectation for the current table row, if any
   bit typed_valid = 1'b0;
   rsp_type typed_rsp;

   function automatic rsp_type compensate(req_type r);
      longint t1, t2, t3, a, b, v1, v2, tf, t;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint x, xh, c, num, p, res;
      longint unsigned xl, bprod, nm, dm, q1, r1, q;
      bit neg;
      rsp_type o;
      o = '0;
      if (r.operation == OP_TEMP) begin
         t1 = longint'(temp_trim_m[15:0]);
         t2 = longint'($signed(temp_trim_m[31:16]));
         t3 = longint'($signed(temp_trim_m[47:32]));
         a = longint'(r.raw_sample >> 3) - t1 * 2;
         b = longint'(r.raw_sample >> 4) - t1;
         v1 = (a * t2) >>> 11;
         v2 = (((b * b) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         fine_temp_m = int'(tf);
         t = (tf * 5 + ROUND_HALF) >>> 8;
         if (t > 64'sd8388607) t = 64'sd8388607;
         if (t < -64'sd8388608) t = -64'sd8388608;
         o.temperature_centi = t[23:0];
         return o;
      end
      p1 = longint'(pres_a_m[15:0]);
      p2 = longint'($signed(pres_a_m[31:16]));
      p3 = longint'($signed(pres_a_m[47:32]));
      p4 = longint'($signed(pres_a_m[63:48]));
      p5 = longint'($signed(pres_b_m[15:0]));
      p6 = longint'($signed(pres_b_m[31:16]));
      p7 = longint'($signed(pres_b_m[47:32]));
      p8 = longint'($signed(pres_b_m[63:48]));
      p9 = longint'($signed(pres_c_m[15:0]));
      v1 = longint'(fine_temp_m) - FINE_OFFSET;
      v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (64'sd1 << 35);
      v1 = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
      // (2^47 + v1) * P1 >> 33 in split form, 64-bit exact
      x = (64'sd1 << 47) + v1;
      xh = x >>> 32;
      xl = longint'(x) & 64'hFFFF_FFFF;
      bprod = xl * longint'(p1);
      c = xh * p1 + longint'(bprod >> 32);
      v1 = c >>> 1;
      if (v1 == 0) begin
         o.divide_by_zero = 1'b1;
         return o;
      end
      num = (longint'(ADC_FULL) - longint'(r.raw_sample)) * (64'sd1 << 31) - v2;
      neg = (num < 0) != (v1 < 0);
      nm = num < 0 ? -num : num;
      dm = v1 < 0 ? -v1 : v1;
      q1 = nm / dm;
      r1 = nm % dm;
      if (q1 > QLIM / PRES_SCALE) q = QLIM;
      else begin
         q = q1 * PRES_SCALE + (r1 * PRES_SCALE) / dm;
         if (q > QLIM) q = QLIM;
      end
      p = neg ? -longint'(q) : longint'(q);
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      res = ((p + v1 + v2) >>> 8) + p7 * 16;
      if (res < 0) res = 0;
      if (res > 64'sh0_FFFF_FFFF) res = 64'sh0_FFFF_FFFF;
      o.pressure_q24_8 = res[31:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // --- monitor: csr writes, req transfers feed the model, rsp checked ---
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_TEMP_TRIM:   temp_trim_m = csr_wdata & 64'h0000_FFFF_FFFF_FFFF;
               CSR_PRES_TRIM_A: pres_a_m = csr_wdata;
               CSR_PRES_TRIM_B: pres_b_m = csr_wdata;
               CSR_PRES_TRIM_C: pres_c_m = csr_wdata & 64'hFFFF;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            e = compensate(req_data);
            if (typed_valid) e = typed_rsp;
            expected_rsps.push_back(e);
            accepted++;
            if (req_data.operation == OP_TEMP) temp_count++;
            else pres_count++;
            if (e.divide_by_zero) dz_count++;
            if (req_data.operation == OP_PRES && e.pressure_q24_8 == 32'hFFFF_FFFF)
               sat_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsps.size() == 0)
               report_mismatch("result with nothing expected");
            else begin
               e = expected_rsps.pop_front();
               if (rsp_data.temperature_centi !== e.temperature_centi)
                  report_mismatch($sformatf("temperature_centi %0d, want %0d",
                     rsp_data.temperature_centi, e.temperature_centi));
               if (rsp_data.pressure_q24_8 !== e.pressure_q24_8)
                  report_mismatch($sformatf("pressure_q24_8 %h, want %h",
                     rsp_data.pressure_q24_8, e.pressure_q24_8));
               if (rsp_data.divide_by_zero !== e.divide_by_zero)
                  report_mismatch($sformatf("divide_by_zero %b, want %b",
                     rsp_data.divide_by_zero, e.divide_by_zero));
            end
         end
      end
   end

   // --- receiver: random stall bursts, one long hold-off, quiet tail ---
   initial begin
      int burst;
      bit held;
      burst = 0;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && accepted >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // --- sender helpers ---
   // one req transfer; valid stays high into the next item when no gap falls
   task automatic send_item(input logic op, input logic [19:0] raw);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= '{operation: op, raw_sample: raw};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every expected result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      typed_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] extreme16();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   // trim value: standard set nudged, fully random, or extreme slices
   function automatic logic [63:0] pick_trim(input logic [63:0] std_val);
      logic [63:0] v;
      int k;
      case ($urandom_range(0, 2))
         0: begin
            v = std_val;
            for (k = 0; k < 4; k++)
               v[k*16 +: 16] = v[k*16 +: 16] + 16'($urandom_range(0, 255)) - 16'd128;
         end
         1: v = {$urandom(), $urandom()};
         default: for (k = 0; k < 4; k++) v[k*16 +: 16] = extreme16();
      endcase
      return v;
   endfunction

   function automatic logic [19:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         2: return 20'h65000 + 20'($urandom_range(0, 20'h1FFF));
         3: return 20'h7E000 + 20'($urandom_range(0, 20'h1FFF));
         default: return 20'($urandom_range(0, 20'hFFFFF));
      endcase
   endfunction

   // --- directed table ---
   typedef struct {
      bit          is_csr;
      logic [1:0]  idx;       // register index for csr rows
      logic        op;
      logic [63:0] value;     // csr data, or raw sample
      bit          typed;
      rsp_type     want;
   } row_type;

   localparam rsp_type RSP_ZERO = '{temperature_centi: '0, pressure_q24_8: '0,
                                    divide_by_zero: 1'b0};
   localparam rsp_type RSP_DZ   = '{temperature_centi: '0, pressure_q24_8: '0,
                                    divide_by_zero: 1'b1};

   row_type table_rows[$];

   function automatic row_type csr_row(input logic [1:0] idx, input logic [63:0] v);
      row_type r;
      r = '{is_csr: 1'b1, idx: idx, op: OP_TEMP, value: v, typed: 1'b0, want: RSP_ZERO};
      return r;
   endfunction

   function automatic row_type item_row(input logic op, input logic [19:0] raw,
                                        input bit typed, input rsp_type want);
      row_type r;
      r = '{is_csr: 1'b0, idx: CSR_TEMP_TRIM, op: op, value: 64'(raw), typed: typed,
            want: want};
      return r;
   endfunction

   initial begin
      int ph, n;
      bit last_csr;
      // reset trims: zero P1 means zero divisor, zero T trims give 0.00 degrees
      table_rows.push_back(item_row(OP_PRES, 20'h00000, 1, RSP_DZ));
      table_rows.push_back(item_row(OP_TEMP, 20'h00000, 1, RSP_ZERO));
      table_rows.push_back(item_row(OP_TEMP, 20'hFFFFF, 1, RSP_ZERO));
      // standard trims; first pressure runs before any real temperature
      table_rows.push_back(csr_row(CSR_TEMP_TRIM, STD_TEMP_TRIM));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_A, STD_PRES_A));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_B, STD_PRES_B));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_C, STD_PRES_C));
      table_rows.push_back(item_row(OP_PRES, 20'h65A80, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_TEMP, 20'h00000, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_TEMP, 20'hFFFFF, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_TEMP, 20'h7EED0, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_PRES, 20'h00000, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_PRES, 20'hFFFFF, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_PRES, 20'h655AC, 0, RSP_ZERO));
      // tiny P1: divisor small enough that the quotient saturates
      table_rows.push_back(csr_row(CSR_PRES_TRIM_A, {STD_PRES_A[63:16], 16'd1}));
      table_rows.push_back(item_row(OP_PRES, 20'h00000, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_PRES, 20'hFFFFF, 0, RSP_ZERO));
      // all-ones and most-negative trims
      table_rows.push_back(csr_row(CSR_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF));
      table_rows.push_back(item_row(OP_TEMP, 20'hFFFFF, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_TEMP, 20'h00000, 0, RSP_ZERO));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_A, 64'hFFFF_FFFF_FFFF_FFFF));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_B, 64'hFFFF_FFFF_FFFF_FFFF));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_C, 64'hFFFF_FFFF_FFFF_8000));
      table_rows.push_back(item_row(OP_PRES, 20'h00000, 0, RSP_ZERO));
      table_rows.push_back(item_row(OP_PRES, 20'h80000, 0, RSP_ZERO));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_B, 64'h8000_8000_8000_8000));
      table_rows.push_back(csr_row(CSR_PRES_TRIM_C, 64'h0000_0000_0000_7FFF));
      table_rows.push_back(item_row(OP_PRES, 20'h12345, 0, RSP_ZERO));
      // P1 back to zero: divisor zero whatever the rest holds
      table_rows.push_back(csr_row(CSR_PRES_TRIM_A, 64'hFFFF_FFFF_FFFF_0000));
      table_rows.push_back(item_row(OP_PRES, 20'hABCDE, 1, RSP_DZ));

      temp_trim_m = '0; pres_a_m = '0; pres_b_m = '0; pres_c_m = '0;
      fine_temp_m = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      last_csr = 1'b1;
      foreach (table_rows[i]) begin
         if (table_rows[i].is_csr) begin
            if (!last_csr) wait_idle();
            write_csr(table_rows[i].idx, table_rows[i].value);
         end else begin
            typed_valid <= table_rows[i].typed;
            typed_rsp <= table_rows[i].want;
            send_item(table_rows[i].op, table_rows[i].value[19:0]);
         end
         last_csr = table_rows[i].is_csr;
      end
      wait_idle();

      // random phases: fresh trims in all four registers, then a run of samples
      n = 0;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_csr(CSR_TEMP_TRIM,   pick_trim(STD_TEMP_TRIM));
         write_csr(CSR_PRES_TRIM_A, pick_trim(STD_PRES_A));
         write_csr(CSR_PRES_TRIM_B, pick_trim(STD_PRES_B));
         write_csr(CSR_PRES_TRIM_C, pick_trim(STD_PRES_C));
         repeat (PHASE_ITEMS) begin
            if (n >= RANDOM_PHASES * PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_item(1'($urandom_range(0, 1)), pick_raw());
            n++;
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
      $display("covered %0d transfers: %0d temperature, %0d pressure",
               accepted, temp_count, pres_count);
      $display("zero divisors %0d, pressures saturated high %0d, results checked %0d",
               dz_count, sat_count, results_seen);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #40_000_000;
      $display("timeout with %0d results outstanding", expected_rsps.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- pressure_temp_compensation.f -----
src/ptc_pkg.sv
src/ptc_mul.sv
src/ptc_div.sv
src/pressure_temp_compensation.sv
sim/testbench.sv
